/* design/disk_head_scheduler_defines.svh */
// -----------------------------------------------------------------------------
// Assertion macros for the disk head scheduler
// Shared property wrappers, clocked on i_clk with i_rst_n as the disable term.
// -----------------------------------------------------------------------------
`ifndef DISK_HEAD_SCHEDULER_DEFINES_SVH
`define DISK_HEAD_SCHEDULER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent
`define DHS_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("disk_head_scheduler: same-cycle check failed");

// Consequent must hold in the cycle after the antecedent
`define DHS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("disk_head_scheduler: next-cycle check failed");

`endif

/* design/dhs_pkg.sv */
// -----------------------------------------------------------------------------
// dhs_pkg
// Widths, codes and controller/datapath interface types of the scheduler.
// -----------------------------------------------------------------------------
package dhs_pkg;

    // Field widths
    localparam int TRACK_W     = 16;
    localparam int DIST_W      = 21;
    localparam int TC_W        = 17;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 17;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 40;
    localparam int OUT_TUSER_W = 2;

    localparam int DEF_MAX_REQUESTS = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TRACK_COUNT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_HEAD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCHED_MODE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SWEEP_UP    = 2'd3;

    // Scheduling policies; the spare code behaves as shortest seek first
    localparam logic [MODE_W-1:0] MODE_SSTF  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_LOOK  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

    // Input item kinds carried on tuser
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_START = 1'b1;

    // Source of the track that a result moves the head to
    typedef enum logic [1:0] {
        SRC_ENTRY,
        SRC_EDGE,
        SRC_HEAD
    } t_src;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic start;
        logic scan_en;
        logic scan_clr;
        logic side_up;
        logic emit;
        t_src src;
        logic last;
        logic finish;
    } t_dp_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic found;
        logic mode_sstf;
        logic mode_scan;
        logic sweep_up;
        logic out_free;
    } t_dp_stat;

endpackage

/* design/dhs_ctrl.sv */
// -----------------------------------------------------------------------------
// dhs_ctrl
// Sequencer: loads, scan passes over the store, phase order and result count.
// -----------------------------------------------------------------------------
module dhs_ctrl import dhs_pkg::*; #(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1,
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_action,
    output logic             o_in_ready,
    input  t_dp_stat         i_stat,
    input  logic [CNT_W-1:0] i_req_count,
    output t_dp_cmd          o_cmd,
    output logic [IDX_W-1:0] o_scan_idx
);

    localparam int OUT_W = $clog2(MAX_REQUESTS + 2);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_PICK = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic PH_FIRST  = 1'b0;
    localparam logic PH_SECOND = 1'b1;

    logic [1:0]       r_state,   n_state;
    logic             r_phase,   n_phase;
    t_src             r_src,     n_src;
    logic [IDX_W-1:0] r_idx,     n_idx;
    logic [OUT_W-1:0] r_total,   n_total;
    logic [OUT_W-1:0] r_emitted, n_emitted;

    logic w_accept;
    logic w_last_entry;
    logic w_emit_last;

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_scan_idx   = r_idx;
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_last_entry = ((CNT_W'(r_idx) + CNT_W'(1)) >= i_req_count);
    assign w_emit_last  = ((r_emitted + OUT_W'(1)) >= r_total);

    // Next state and commands
    always_comb begin
        n_state   = r_state;
        n_phase   = r_phase;
        n_src     = r_src;
        n_idx     = r_idx;
        n_total   = r_total;
        n_emitted = r_emitted;

        o_cmd          = '0;
        o_cmd.src      = r_src;
        o_cmd.side_up  = (r_phase == PH_FIRST) ? i_stat.sweep_up : !i_stat.sweep_up;

        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    if (i_in_action == ACT_START) begin
                        o_cmd.start = 1'b1;
                        n_total     = OUT_W'(i_req_count) + OUT_W'(i_stat.mode_scan);
                        n_emitted   = '0;
                        n_phase     = PH_FIRST;
                        n_idx       = '0;
                        if (n_total == '0) begin
                            n_src   = SRC_HEAD;
                            n_state = ST_EMIT;
                        end else begin
                            o_cmd.scan_clr = 1'b1;
                            n_state        = ST_SCAN;
                        end
                    end else begin
                        o_cmd.load = 1'b1;
                    end
                end
            end
            ST_SCAN: begin
                // Visit one stored entry per cycle
                o_cmd.scan_en = 1'b1;
                if (w_last_entry) begin
                    n_state = ST_PICK;
                end else begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_PICK: begin
                if (i_stat.found) begin
                    n_src   = SRC_ENTRY;
                    n_state = ST_EMIT;
                end else if ((r_phase == PH_FIRST) && !i_stat.mode_sstf) begin
                    // First side exhausted: edge trip or turn around
                    if (i_stat.mode_scan) begin
                        n_src   = SRC_EDGE;
                        n_state = ST_EMIT;
                    end else begin
                        n_phase        = PH_SECOND;
                        n_idx          = '0;
                        o_cmd.scan_clr = 1'b1;
                        o_cmd.side_up  = !i_stat.sweep_up;
                        n_state        = ST_SCAN;
                    end
                end else begin
                    o_cmd.finish = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            ST_EMIT: begin
                // Commit the move once the output register is free
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = w_emit_last;
                    n_emitted  = r_emitted + OUT_W'(1);
                    if (w_emit_last) begin
                        o_cmd.finish = 1'b1;
                        n_state      = ST_IDLE;
                    end else begin
                        if (r_src == SRC_EDGE) begin
                            n_phase = PH_SECOND;
                        end
                        n_idx          = '0;
                        o_cmd.scan_clr = 1'b1;
                        n_state        = ST_SCAN;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_phase   <= PH_FIRST;
            r_src     <= SRC_HEAD;
            r_idx     <= '0;
            r_total   <= '0;
            r_emitted <= '0;
        end else begin
            r_state   <= n_state;
            r_phase   <= n_phase;
            r_src     <= n_src;
            r_idx     <= n_idx;
            r_total   <= n_total;
            r_emitted <= n_emitted;
        end
    end

endmodule

/* design/dhs_datapath.sv */
// -----------------------------------------------------------------------------
// dhs_datapath
// Request store, served marks, configuration, best-candidate scan, head and
// distance registers, and the result register.
// -----------------------------------------------------------------------------
module dhs_datapath import dhs_pkg::*; #(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS,
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1,
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1)
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [TRACK_W-1:0]    i_req_track,
    input  t_dp_cmd               i_cmd,
    input  logic [IDX_W-1:0]      i_scan_idx,
    output t_dp_stat              o_stat,
    output logic [CNT_W-1:0]      o_req_count,
    input  logic                  i_out_ready,
    output logic                  o_out_valid,
    output logic [TRACK_W-1:0]    o_out_track,
    output logic [DIST_W-1:0]     o_out_dist,
    output logic                  o_out_edge,
    output logic                  o_out_empty,
    output logic                  o_out_last
);

    localparam logic [TC_W-1:0]   TRACK_COUNT_RST = 17'h10000;
    localparam logic [DIST_W-1:0] DIST_MAX        = '1;

    function automatic logic [TRACK_W-1:0] abs_diff(input logic [TRACK_W-1:0] a,
                                                    input logic [TRACK_W-1:0] b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Configuration
    logic [TC_W-1:0]    r_track_count;
    logic [TRACK_W-1:0] r_start_head;
    logic [MODE_W-1:0]  r_mode;
    logic               r_sweep_up;

    // Request store and run state
    logic [TRACK_W-1:0] r_store [MAX_REQUESTS];
    logic [MAX_REQUESTS-1:0] r_marks;
    logic [CNT_W-1:0]   r_count;
    logic [TRACK_W-1:0] r_head;
    logic [DIST_W-1:0]  r_dist;

    // Best candidate of the current scan
    logic               r_found;
    logic [IDX_W-1:0]   r_best_idx;
    logic [TRACK_W-1:0] r_best_key;
    logic [TRACK_W-1:0] r_best_track;

    // Result register
    logic               r_out_valid;
    logic [TRACK_W-1:0] r_out_track;
    logic [DIST_W-1:0]  r_out_dist;
    logic               r_out_edge;
    logic               r_out_empty;
    logic               r_out_last;

    logic               w_sstf;
    logic               w_scan;
    logic [TRACK_W-1:0] w_cur_track;
    logic               w_live;
    logic [TRACK_W-1:0] w_key;
    logic               w_in_side;
    logic               w_improves;
    logic               w_take;
    logic               w_load_ok;
    logic [TC_W-1:0]    w_tc_m1;
    logic [TRACK_W-1:0] w_top;
    logic [TRACK_W-1:0] w_edge_track;
    logic [TRACK_W-1:0] w_target;
    logic [DIST_W:0]    w_sum;
    logic [DIST_W-1:0]  w_new_dist;
    logic               w_out_free;

    assign w_scan     = (r_mode == MODE_SCAN);
    assign w_sstf     = (r_mode != MODE_SCAN) && (r_mode != MODE_LOOK);
    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load_ok  = i_cmd.load && (r_count < CNT_W'(MAX_REQUESTS));

    // Evaluate the entry under the scan pointer
    always_comb begin
        w_cur_track = r_store[i_scan_idx];
        w_live      = (CNT_W'(i_scan_idx) < r_count) && !r_marks[i_scan_idx];
        w_key       = w_sstf ? abs_diff(r_head, w_cur_track) : w_cur_track;
        w_in_side   = w_sstf || (i_cmd.side_up == (w_cur_track >= r_start_head));
        // Upward and nearest keep the earlier load on a tie, downward the later
        if (!r_found) begin
            w_improves = 1'b1;
        end else if (w_sstf || i_cmd.side_up) begin
            w_improves = (w_key < r_best_key);
        end else begin
            w_improves = (w_key >= r_best_key);
        end
        w_take = i_cmd.scan_en && w_live && w_in_side && w_improves;
    end

    // Edge track and move target
    always_comb begin
        w_tc_m1 = r_track_count - TC_W'(1);
        if (r_track_count == '0) begin
            w_top = '0;
        end else if (w_tc_m1[TC_W-1]) begin
            w_top = '1;
        end else begin
            w_top = w_tc_m1[TRACK_W-1:0];
        end
        w_edge_track = r_sweep_up ? w_top : '0;

        unique case (i_cmd.src)
            SRC_ENTRY: w_target = r_best_track;
            SRC_EDGE:  w_target = w_edge_track;
            SRC_HEAD:  w_target = r_head;
            default:   w_target = r_head;
        endcase

        // Saturating distance sum
        w_sum      = {1'b0, r_dist} + (DIST_W + 1)'(abs_diff(r_head, w_target));
        w_new_dist = w_sum[DIST_W] ? DIST_MAX : w_sum[DIST_W-1:0];
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track_count <= TRACK_COUNT_RST;
            r_start_head  <= '0;
            r_mode        <= '0;
            r_sweep_up    <= 1'b1;
            r_marks       <= '0;
            r_count       <= '0;
            r_head        <= '0;
            r_dist        <= '0;
            r_found       <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // Register writes
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    REG_TRACK_COUNT: r_track_count <= i_cfg_data[TC_W-1:0];
                    REG_START_HEAD:  r_start_head  <= i_cfg_data[TRACK_W-1:0];
                    REG_SCHED_MODE:  r_mode        <= i_cfg_data[MODE_W-1:0];
                    REG_SWEEP_UP:    r_sweep_up    <= i_cfg_data[0];
                endcase
            end

            // Append a request while room remains
            if (w_load_ok) begin
                r_marks[r_count[IDX_W-1:0]] <= 1'b0;
                r_count                     <= r_count + CNT_W'(1);
            end

            if (i_cmd.start) begin
                r_head <= r_start_head;
                r_dist <= '0;
            end

            // Track the best candidate of the scan
            if (i_cmd.scan_clr) begin
                r_found <= 1'b0;
            end else if (w_take) begin
                r_found <= 1'b1;
            end

            // Commit a head move; the final move leaves marking to the clear below
            if (i_cmd.emit) begin
                r_head <= w_target;
                r_dist <= w_new_dist;
                if ((i_cmd.src == SRC_ENTRY) && !i_cmd.finish) begin
                    r_marks[r_best_idx] <= 1'b1;
                end
            end

            // Empty the store at the end of a run
            if (i_cmd.finish) begin
                r_count <= '0;
                r_marks <= '0;
            end

            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (w_load_ok) begin
            r_store[r_count[IDX_W-1:0]] <= i_req_track;
        end
        if (w_take) begin
            r_best_idx   <= i_scan_idx;
            r_best_key   <= w_key;
            r_best_track <= w_cur_track;
        end
        if (i_cmd.emit) begin
            r_out_track <= w_target;
            r_out_dist  <= w_new_dist;
            r_out_edge  <= (i_cmd.src == SRC_EDGE);
            r_out_empty <= (i_cmd.src != SRC_ENTRY) && (r_count == '0);
            r_out_last  <= i_cmd.last;
        end
    end

    assign o_stat.found     = r_found;
    assign o_stat.mode_sstf = w_sstf;
    assign o_stat.mode_scan = w_scan;
    assign o_stat.sweep_up  = r_sweep_up;
    assign o_stat.out_free  = w_out_free;
    assign o_req_count      = r_count;

    assign o_out_valid = r_out_valid;
    assign o_out_track = r_out_track;
    assign o_out_dist  = r_out_dist;
    assign o_out_edge  = r_out_edge;
    assign o_out_empty = r_out_empty;
    assign o_out_last  = r_out_last;

endmodule

/* design/disk_head_scheduler.sv */
// -----------------------------------------------------------------------------
// disk_head_scheduler: SSTF, SCAN and LOOK scheduler, one item at a time. After a start
// each move scans the N stored requests, picks the best candidate and commits it; a LOOK
// turn adds a second scan, an empty run without an edge visit commits without a scan, and
// a stalled output holds the commit.
// Synchronous reset empties the store, clears marks, restores register defaults.
// -----------------------------------------------------------------------------
`include "disk_head_scheduler_defines.svh"

module disk_head_scheduler import dhs_pkg::*; #(
    parameter int MAX_REQUESTS = DEF_MAX_REQUESTS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [15:0] request_track
    input  logic                   s_axis_tuser,   // [0] action
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [15:0] served_track, [36:16] total_distance
    output logic [OUT_TUSER_W-1:0] m_axis_tuser,   // [0] edge_visit, [1] empty_run
    output logic                   m_axis_tlast
);

    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);

    t_dp_cmd            w_cmd;
    t_dp_stat           w_stat;
    logic [IDX_W-1:0]   w_scan_idx;
    logic [CNT_W-1:0]   w_req_count;
    logic [TRACK_W-1:0] w_out_track;
    logic [DIST_W-1:0]  w_out_dist;
    logic               w_out_edge;
    logic               w_out_empty;

    dhs_ctrl #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_in_action (s_axis_tuser),
        .o_in_ready  (s_axis_tready),
        .i_stat      (w_stat),
        .i_req_count (w_req_count),
        .o_cmd       (w_cmd),
        .o_scan_idx  (w_scan_idx)
    );

    dhs_datapath #(
        .MAX_REQUESTS (MAX_REQUESTS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_req_track (s_axis_tdata[TRACK_W-1:0]),
        .i_cmd       (w_cmd),
        .i_scan_idx  (w_scan_idx),
        .o_stat      (w_stat),
        .o_req_count (w_req_count),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_track (w_out_track),
        .o_out_dist  (w_out_dist),
        .o_out_edge  (w_out_edge),
        .o_out_empty (w_out_empty),
        .o_out_last  (m_axis_tlast)
    );

    // Pack result fields, zero fill to whole bytes
    assign m_axis_tdata = {(OUT_TDATA_W - TRACK_W - DIST_W)'(0), w_out_dist, w_out_track};
    assign m_axis_tuser = {w_out_empty, w_out_edge};

    // Checks
    `DHS_ASSERT_SAME(a_emit_needs_room, w_cmd.emit, w_stat.out_free)
    `DHS_ASSERT_SAME(a_empty_run_is_last, m_axis_tvalid && m_axis_tuser[1], m_axis_tlast)
    `DHS_ASSERT_NEXT(a_run_end_empties, w_cmd.emit && w_cmd.last, w_req_count == '0)
    `DHS_ASSERT_SAME(a_count_bounded, 1'b1, w_req_count <= CNT_W'(MAX_REQUESTS))

endmodule
